/* rtl/edcu_pkg.sv */
// ============================================================================
// edcu_pkg - shared types and constants for the congestion window unit
// Field widths, opcodes, the front-to-back transaction record and the
// constants used by the gradient test (mod-100 reciprocal, byte residues).
// ============================================================================
package edcu_pkg;

    localparam int unsigned OP_W      = 2;
    localparam int unsigned WORD_W    = 32;
    localparam int unsigned RTT_SHIFT = 3;
    localparam int unsigned RTT_W     = WORD_W - RTT_SHIFT;
    localparam int unsigned LOW_W     = 16;
    localparam int unsigned ACKED_W   = 16;
    localparam int unsigned PLAST_W   = 10;
    localparam int unsigned ENT_W     = 4;
    localparam int unsigned HIST_W    = 8;

    // gradient datapath widths
    localparam int unsigned FOLD_W      = 15;                  // byte fold of excess, < 24212
    localparam int unsigned PROD_W      = FOLD_W + PLAST_W;    // fold * plasticity
    localparam int unsigned RECIP_W     = 26;
    localparam int unsigned RECIP_SHIFT = 32;
    localparam int unsigned QUOT_W      = PROD_W + RECIP_W - RECIP_SHIFT;
    localparam int unsigned REM_W       = 7;
    localparam int unsigned GRAD_W      = WORD_W + PLAST_W + 2; // (33b signed) * (11b signed)
    localparam int unsigned THR_W       = 13;

    localparam int unsigned FQ_DEPTH = 2;

    localparam logic [PLAST_W-1:0] PLAST_MAX  = 10'd600;
    localparam logic [PLAST_W-1:0] PLAST_BASE = 10'd100;
    localparam logic [PLAST_W-1:0] PLAST_STEP = 10'd50;
    localparam logic [ENT_W-1:0]   ENT_MAX    = ENT_W'(HIST_W);
    localparam logic [WORD_W-1:0]  ALL_ONES   = '1;
    localparam logic [WORD_W-1:0]  SSTH_FLOOR = 32'd2;

    // floor(v / 100) = (v * MOD_RECIP) >> 32, exact for v < 2^30
    localparam logic [RECIP_W-1:0] MOD_RECIP = 26'd42949673;
    localparam int unsigned        DIVISOR   = 100;

    // 256^k mod 100 for k = 1, 2, 3
    localparam int unsigned RES_B1 = 56;
    localparam int unsigned RES_B2 = 36;
    localparam int unsigned RES_B3 = 16;

    // gradient > 0  <=>  (cwnd - excess) * p + (excess * p mod 100) >= 400 * entropy + 100
    localparam int unsigned ENT_WEIGHT = 400;
    localparam int unsigned GRAD_BIAS  = 100;

    typedef enum logic [OP_W-1:0] {
        OP_START = 2'd0,
        OP_ACK   = 2'd1,
        OP_LOSS  = 2'd2,
        OP_CONG  = 2'd3
    } t_opcode;

    typedef enum logic [1:0] {
        KIND_PASS = 2'd0,
        KIND_ACK  = 2'd1,
        KIND_CONG = 2'd2
    } t_kind;

    typedef struct packed {
        t_kind               kind;
        logic [WORD_W-1:0]   cwnd;
        logic [WORD_W-1:0]   ssth;
        logic [WORD_W-1:0]   cnt;
        logic [ACKED_W-1:0]  acked;
        logic [RTT_W-1:0]    rtt_excess;
        logic [PLAST_W-1:0]  plast;
        logic [ENT_W-1:0]    ent;
    } t_edcu_rec;

endpackage

/* rtl/edcu_front.sv */
// ============================================================================
// edcu_front - event classifier and per-connection state
// Updates trend history, entropy, minimum RTT and plasticity on accepted
// transactions, as the opcode selects, and forms the record handed to the back end.
// ============================================================================
module edcu_front (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_accept,
    input  logic [edcu_pkg::OP_W-1:0]     i_opcode,
    input  logic [edcu_pkg::WORD_W-1:0]   i_smoothed_rtt_x8,
    input  logic [edcu_pkg::ACKED_W-1:0]  i_acked_segments,
    input  logic                          i_window_limited,
    input  logic [edcu_pkg::WORD_W-1:0]   i_cwnd_in,
    input  logic [edcu_pkg::WORD_W-1:0]   i_ssthresh_in,
    input  logic [edcu_pkg::WORD_W-1:0]   i_ai_count_in,
    output edcu_pkg::t_edcu_rec           o_rec
);
    import edcu_pkg::*;

    logic [WORD_W-1:0]  r_min_rtt, n_min_rtt;
    logic [PLAST_W-1:0] r_plast, n_plast;
    logic [HIST_W-1:0]  r_hist, n_hist;
    logic [LOW_W-1:0]   r_prev_low, n_prev_low;
    logic [ENT_W-1:0]   r_ent, n_ent;

    t_opcode            op;
    t_kind              kind;
    logic [RTT_W-1:0]   rtt;
    logic [WORD_W-1:0]  rtt_word;
    logic [WORD_W-1:0]  diff_word;
    logic               trend;
    logic [HIST_W-1:0]  hist_ack;
    logic [HIST_W-1:0]  trans;
    logic [ENT_W-1:0]   ent_ack;
    logic               min_take;
    logic [RTT_W-1:0]   excess;
    logic [PLAST_W:0]   loss_sum;
    logic [PLAST_W+1:0] decay;

    assign op       = t_opcode'(i_opcode);
    assign rtt      = i_smoothed_rtt_x8[WORD_W-1:RTT_SHIFT];
    assign rtt_word = {{RTT_SHIFT{1'b0}}, rtt};
    assign trend    = rtt > {{(RTT_W-LOW_W){1'b0}}, r_prev_low};
    assign hist_ack = {r_hist[HIST_W-2:0], trend};
    assign trans    = hist_ack ^ {1'b0, hist_ack[HIST_W-1:1]};

    always_comb begin
        ent_ack = '0;
        for (int i = 0; i < HIST_W; i++) begin
            ent_ack = ent_ack + ENT_W'(trans[i]);
        end
    end

    // new minimum when below it, or when the minimum holds zero
    assign min_take  = (rtt_word < r_min_rtt) || (r_min_rtt == '0);
    assign diff_word = rtt_word - r_min_rtt;
    // excess over the updated minimum; zero when the minimum was just taken
    assign excess    = (!min_take && (rtt_word > r_min_rtt)) ? diff_word[RTT_W-1:0] : '0;

    assign loss_sum = {1'b0, r_plast} + {1'b0, PLAST_STEP};
    assign decay    = {1'b0, r_plast, 1'b0} + {2'b00, r_plast};   // 3 * p

    always_comb begin
        n_min_rtt  = r_min_rtt;
        n_plast    = r_plast;
        n_hist     = r_hist;
        n_prev_low = r_prev_low;
        n_ent      = r_ent;
        kind       = KIND_PASS;
        unique case (op)
            OP_START: begin
                n_min_rtt  = ALL_ONES;
                n_plast    = PLAST_BASE;
                n_hist     = '0;
                n_prev_low = '0;
                n_ent      = '0;
            end
            OP_ACK: begin
                if (i_window_limited) begin
                    kind       = KIND_ACK;
                    n_hist     = hist_ack;
                    n_prev_low = rtt[LOW_W-1:0];
                    n_ent      = ent_ack;
                    if (min_take) begin
                        n_min_rtt = rtt_word;
                    end
                end
            end
            OP_LOSS: begin
                n_plast = (loss_sum > {1'b0, PLAST_MAX}) ? PLAST_MAX : loss_sum[PLAST_W-1:0];
            end
            OP_CONG: begin
                kind = KIND_CONG;
                if (r_plast > PLAST_BASE) begin
                    n_plast = decay[PLAST_W+1:2];
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_rtt  <= ALL_ONES;
            r_plast    <= PLAST_BASE;
            r_hist     <= '0;
            r_prev_low <= '0;
            r_ent      <= '0;
        end else if (i_accept) begin
            r_min_rtt  <= n_min_rtt;
            r_plast    <= n_plast;
            r_hist     <= n_hist;
            r_prev_low <= n_prev_low;
            r_ent      <= n_ent;
        end
    end

    always_comb begin
        o_rec.kind       = kind;
        o_rec.cwnd       = i_cwnd_in;
        o_rec.ssth       = i_ssthresh_in;
        o_rec.cnt        = i_ai_count_in;
        o_rec.acked      = i_acked_segments;
        o_rec.rtt_excess = excess;
        o_rec.plast      = n_plast;
        o_rec.ent        = n_ent;
    end

endmodule

/* rtl/edcu_queue.sv */
// ============================================================================
// edcu_queue - record queue between front and back
// Register-based FIFO of transaction records; DEPTH must be 2 or more.
// ============================================================================
module edcu_queue #(
    parameter int unsigned DEPTH = edcu_pkg::FQ_DEPTH
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_wr,
    input  edcu_pkg::t_edcu_rec  i_wdata,
    output logic                 o_full,
    input  logic                 i_rd,
    output edcu_pkg::t_edcu_rec  o_rdata,
    output logic                 o_empty
);
    import edcu_pkg::*;

    localparam int unsigned PTR_W = $clog2(DEPTH);
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    t_edcu_rec         r_mem [DEPTH];
    logic [PTR_W-1:0]  r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0]  r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0]  r_count, n_count;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_rdata = r_mem[r_rd_ptr];

    assign n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
    assign n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;

    always_comb begin
        n_count = r_count;
        if (i_wr && !i_rd) begin
            n_count = r_count + 1'b1;
        end else if (i_rd && !i_wr) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_count <= n_count;
            if (i_wr) begin
                r_wr_ptr <= n_wr_ptr;
            end
            if (i_rd) begin
                r_rd_ptr <= n_rd_ptr;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            r_mem[r_wr_ptr] <= i_wdata;
        end
    end

endmodule

/* rtl/edcu_back.sv */
// ============================================================================
// edcu_back - window update pipeline
// Four stages: operand prep, excess*p, mod-100 reciprocal, gradient test and
// result select. The last stage is the output register; all stages stall
// together while a result waits.
// ============================================================================
module edcu_back (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_rec_valid,
    input  edcu_pkg::t_edcu_rec           i_rec,
    output logic                          o_rec_take,
    input  logic                          i_pop,
    output logic                          o_empty,
    output logic [edcu_pkg::WORD_W-1:0]   o_cwnd_out,
    output logic [edcu_pkg::WORD_W-1:0]   o_ai_count_out,
    output logic [edcu_pkg::WORD_W-1:0]   o_ssthresh_out,
    output logic [edcu_pkg::PLAST_W-1:0]  o_plasticity_out,
    output logic [edcu_pkg::ENT_W-1:0]    o_entropy_out
);
    import edcu_pkg::*;

    typedef struct packed {
        logic                      avoid;
        logic [WORD_W-1:0]         base_cwnd;
        logic [WORD_W-1:0]         base_cnt;
        logic [WORD_W-1:0]         base_ssth;
        logic [PLAST_W-1:0]        plast;
        logic [ENT_W-1:0]          ent;
        logic [WORD_W-1:0]         cwnd;
        logic [WORD_W-1:0]         cwnd_inc;
        logic [WORD_W-1:0]         cnt2;
        logic                      a_ge;
        logic signed [GRAD_W-1:0]  grad;
        logic [FOLD_W-1:0]         fold;
    } t_s1;

    typedef struct packed {
        logic                      avoid;
        logic [WORD_W-1:0]         base_cwnd;
        logic [WORD_W-1:0]         base_cnt;
        logic [WORD_W-1:0]         base_ssth;
        logic [PLAST_W-1:0]        plast;
        logic [ENT_W-1:0]          ent;
        logic [WORD_W-1:0]         cwnd;
        logic [WORD_W-1:0]         cwnd_inc;
        logic [WORD_W-1:0]         cnt3;
        logic [1:0]                n_inc;
        logic signed [GRAD_W-1:0]  grad;
        logic [PROD_W-1:0]         prod;
    } t_s2;

    typedef struct packed {
        logic                      avoid;
        logic [WORD_W-1:0]         base_cwnd;
        logic [WORD_W-1:0]         base_cnt;
        logic [WORD_W-1:0]         base_ssth;
        logic [PLAST_W-1:0]        plast;
        logic [ENT_W-1:0]          ent;
        logic [WORD_W-1:0]         cwnd_inc;
        logic [WORD_W-1:0]         ai_cwnd;
        logic [WORD_W-1:0]         cnt3;
        logic signed [GRAD_W-1:0]  grad;
        logic [PROD_W-1:0]         prod;
        logic [QUOT_W-1:0]         quot;
    } t_s3;

    t_s1 r_s1, n_s1;
    t_s2 r_s2, n_s2;
    t_s3 r_s3, n_s3;
    logic r_v1, r_v2, r_v3, r_v4;
    logic en;

    logic [WORD_W-1:0]           r_cwnd, n_cwnd;
    logic [WORD_W-1:0]           r_cnt, n_cnt;
    logic [WORD_W-1:0]           r_ssth;
    logic [PLAST_W-1:0]          r_plast;
    logic [ENT_W-1:0]            r_ent;

    // stage 1 signals
    logic                        slow;
    logic [WORD_W:0]             ss_sum;
    logic [WORD_W-1:0]           ss_new;
    logic [WORD_W-1:0]           half;
    logic [WORD_W-1:0]           cong_ssth;
    logic signed [WORD_W:0]      cw_minus_ex;
    logic signed [PLAST_W:0]     plast_s;
    logic [RTT_W-1:0]            ex;
    // stage 2/3/4 signals
    logic                        b_ge;
    logic [PROD_W+RECIP_W-1:0]   qprod;
    logic [WORD_W:0]             ai_sum;
    logic [PROD_W-1:0]           rem_full;
    logic [REM_W-1:0]            rem;
    logic [THR_W-1:0]            thr_u;
    logic signed [GRAD_W:0]      lhs;
    logic signed [GRAD_W:0]      thr;
    logic                        grow;

    assign en         = !r_v4 || i_pop;
    assign o_rec_take = en && i_rec_valid;
    assign o_empty    = !r_v4;

    // ---- stage 1: classify ack path, prep ai counter, fold excess, grad product
    assign slow      = i_rec.cwnd <= i_rec.ssth;
    assign ss_sum    = {1'b0, i_rec.cwnd} + {{(WORD_W+1-ACKED_W){1'b0}}, i_rec.acked};
    assign ss_new    = (ss_sum < {1'b0, i_rec.ssth}) ? ss_sum[WORD_W-1:0] : i_rec.ssth;
    assign half      = {1'b0, i_rec.cwnd[WORD_W-1:1]};
    assign cong_ssth = (half > SSTH_FLOOR) ? half : SSTH_FLOOR;
    assign ex        = i_rec.rtt_excess;
    assign cw_minus_ex = $signed({1'b0, i_rec.cwnd})
                       - $signed({{(WORD_W+1-RTT_W){1'b0}}, ex});
    assign plast_s   = $signed({1'b0, i_rec.plast});

    always_comb begin
        n_s1.avoid     = (i_rec.kind == KIND_ACK) && !slow;
        n_s1.base_cwnd = i_rec.cwnd;
        n_s1.base_cnt  = i_rec.cnt;
        n_s1.base_ssth = i_rec.ssth;
        unique case (i_rec.kind)
            KIND_ACK: begin
                if (slow) begin
                    n_s1.base_cwnd = ss_new;
                end
            end
            KIND_CONG: begin
                n_s1.base_ssth = cong_ssth;
            end
            default: begin
                n_s1.base_cwnd = i_rec.cwnd;
            end
        endcase
        n_s1.plast    = i_rec.plast;
        n_s1.ent      = i_rec.ent;
        n_s1.cwnd     = i_rec.cwnd;
        n_s1.cwnd_inc = (i_rec.cwnd == ALL_ONES) ? i_rec.cwnd : i_rec.cwnd + 1'b1;
        n_s1.a_ge     = i_rec.cnt >= i_rec.cwnd;
        n_s1.cnt2     = (n_s1.a_ge ? '0 : i_rec.cnt) + 1'b1;
        n_s1.grad     = GRAD_W'(cw_minus_ex) * GRAD_W'(plast_s);
        // excess mod 100 preserved: bytes weighted by 256^k mod 100
        n_s1.fold     = FOLD_W'(ex[7:0])
                      + FOLD_W'(ex[15:8]) * FOLD_W'(RES_B1)
                      + FOLD_W'(ex[23:16]) * FOLD_W'(RES_B2)
                      + FOLD_W'(ex[RTT_W-1:24]) * FOLD_W'(RES_B3);
    end

    // ---- stage 2: folded excess times plasticity, second ai compare
    assign b_ge = r_s1.cnt2 >= r_s1.cwnd;

    always_comb begin
        n_s2.avoid     = r_s1.avoid;
        n_s2.base_cwnd = r_s1.base_cwnd;
        n_s2.base_cnt  = r_s1.base_cnt;
        n_s2.base_ssth = r_s1.base_ssth;
        n_s2.plast     = r_s1.plast;
        n_s2.ent       = r_s1.ent;
        n_s2.cwnd      = r_s1.cwnd;
        n_s2.cwnd_inc  = r_s1.cwnd_inc;
        n_s2.cnt3      = b_ge ? r_s1.cnt2 - r_s1.cwnd : r_s1.cnt2;
        n_s2.n_inc     = {1'b0, r_s1.a_ge} + {1'b0, b_ge};
        n_s2.grad      = r_s1.grad;
        n_s2.prod      = PROD_W'(r_s1.fold) * PROD_W'(r_s1.plast);
    end

    // ---- stage 3: quotient by reciprocal, saturating ai window
    assign qprod  = (PROD_W+RECIP_W)'(r_s2.prod) * (PROD_W+RECIP_W)'(MOD_RECIP);
    assign ai_sum = {1'b0, r_s2.cwnd} + (WORD_W+1)'(r_s2.n_inc);

    always_comb begin
        n_s3.avoid     = r_s2.avoid;
        n_s3.base_cwnd = r_s2.base_cwnd;
        n_s3.base_cnt  = r_s2.base_cnt;
        n_s3.base_ssth = r_s2.base_ssth;
        n_s3.plast     = r_s2.plast;
        n_s3.ent       = r_s2.ent;
        n_s3.cwnd_inc  = r_s2.cwnd_inc;
        n_s3.ai_cwnd   = ai_sum[WORD_W] ? ALL_ONES : ai_sum[WORD_W-1:0];
        n_s3.cnt3      = r_s2.cnt3;
        n_s3.grad      = r_s2.grad;
        n_s3.prod      = r_s2.prod;
        n_s3.quot      = qprod[RECIP_SHIFT +: QUOT_W];
    end

    // ---- stage 4: gradient sign test and result select
    assign rem_full = r_s3.prod - PROD_W'(r_s3.quot) * PROD_W'(DIVISOR);
    assign rem      = rem_full[REM_W-1:0];
    assign thr_u    = THR_W'(r_s3.ent) * THR_W'(ENT_WEIGHT) + THR_W'(GRAD_BIAS);
    assign lhs      = {r_s3.grad[GRAD_W-1], r_s3.grad}
                    + $signed({{(GRAD_W+1-REM_W){1'b0}}, rem});
    assign thr      = $signed({{(GRAD_W+1-THR_W){1'b0}}, thr_u});
    assign grow     = lhs >= thr;

    always_comb begin
        n_cwnd = r_s3.base_cwnd;
        n_cnt  = r_s3.base_cnt;
        if (r_s3.avoid) begin
            if (grow) begin
                n_cwnd = r_s3.cwnd_inc;
            end else begin
                n_cwnd = r_s3.ai_cwnd;
                n_cnt  = r_s3.cnt3;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else if (en) begin
            r_v1 <= i_rec_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s1    <= n_s1;
            r_s2    <= n_s2;
            r_s3    <= n_s3;
            r_cwnd  <= n_cwnd;
            r_cnt   <= n_cnt;
            r_ssth  <= r_s3.base_ssth;
            r_plast <= r_s3.plast;
            r_ent   <= r_s3.ent;
        end
    end

    assign o_cwnd_out       = r_cwnd;
    assign o_ai_count_out   = r_cnt;
    assign o_ssthresh_out   = r_ssth;
    assign o_plasticity_out = r_plast;
    assign o_entropy_out    = r_ent;

endmodule

/* rtl/entropy_damped_cwnd_update_unit.sv */
// ============================================================================
// entropy_damped_cwnd_update_unit - congestion window update, entropy damped
// Throughput: one transaction per cycle while results are popped; the 4-stage
//   back pipeline stalls while a result waits and pop is low, and the front state
//   update takes one transaction a cycle while the record queue is not full.
// Reset: synchronous, active low; restores plasticity 100, minimum RTT all
//   ones, history/entropy zero, and empties the record queue and pipeline.
// ============================================================================
//
// Structure
//   front : takes a transaction when push is high and full is low. It owns the
//           per-connection state (trend history, entropy, minimum RTT, previous
//           RTT low half, plasticity), updates it in the same cycle and writes a
//           record (event kind, inputs, RTT excess over minimum, post-update
//           plasticity and entropy) into the record queue.
//   queue : short FIFO; full here is the input side's full.
//   back  : feed-forward pipeline, no connection state. It resolves slow start,
//           congestion event ssthresh and the Reno ack counter, and tests the
//           sign of the gradient without a divider:
//             g > 0  <=>  (cwnd - excess)*p + ((excess*p) mod 100) >= 400*ent + 100
//           (excess*p) mod 100 comes from a byte fold of excess (256^k mod 100),
//           one small product and a reciprocal multiply.
//   Its last stage is the output register; the whole pipe stalls only while
//   a finished result is waiting and pop is low, while the front keeps
//   taking transactions into the queue until it is full.
//
module entropy_damped_cwnd_update_unit #(
    parameter int unsigned FRONT_QUEUE_DEPTH = edcu_pkg::FQ_DEPTH
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // input queue side
    input  logic                          push,
    output logic                          full,
    input  logic [edcu_pkg::OP_W-1:0]     i_opcode,
    input  logic [edcu_pkg::WORD_W-1:0]   i_smoothed_rtt_x8,
    input  logic [edcu_pkg::ACKED_W-1:0]  i_acked_segments,
    input  logic                          i_window_limited,
    input  logic [edcu_pkg::WORD_W-1:0]   i_cwnd_in,
    input  logic [edcu_pkg::WORD_W-1:0]   i_ssthresh_in,
    input  logic [edcu_pkg::WORD_W-1:0]   i_ai_count_in,
    // result queue side
    output logic                          empty,
    input  logic                          pop,
    output logic [edcu_pkg::WORD_W-1:0]   o_cwnd_out,
    output logic [edcu_pkg::WORD_W-1:0]   o_ai_count_out,
    output logic [edcu_pkg::WORD_W-1:0]   o_ssthresh_out,
    output logic [edcu_pkg::PLAST_W-1:0]  o_plasticity_out,
    output logic [edcu_pkg::ENT_W-1:0]    o_entropy_out
);
    import edcu_pkg::*;

    logic       accept;        // input transaction taken this edge
    t_edcu_rec  front_rec;     // record built from inputs and current state
    t_edcu_rec  queue_rec;     // oldest queued record
    logic       queue_empty;
    logic       back_take;     // back pipeline pulls a record

    assign accept = push && !full;

    edcu_front u_front (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_accept          (accept),
        .i_opcode          (i_opcode),
        .i_smoothed_rtt_x8 (i_smoothed_rtt_x8),
        .i_acked_segments  (i_acked_segments),
        .i_window_limited  (i_window_limited),
        .i_cwnd_in         (i_cwnd_in),
        .i_ssthresh_in     (i_ssthresh_in),
        .i_ai_count_in     (i_ai_count_in),
        .o_rec             (front_rec)
    );

    edcu_queue #(
        .DEPTH (FRONT_QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (accept),
        .i_wdata (front_rec),
        .o_full  (full),
        .i_rd    (back_take),
        .o_rdata (queue_rec),
        .o_empty (queue_empty)
    );

    edcu_back u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_rec_valid      (!queue_empty),
        .i_rec            (queue_rec),
        .o_rec_take       (back_take),
        .i_pop            (pop),
        .o_empty          (empty),
        .o_cwnd_out       (o_cwnd_out),
        .o_ai_count_out   (o_ai_count_out),
        .o_ssthresh_out   (o_ssthresh_out),
        .o_plasticity_out (o_plasticity_out),
        .o_entropy_out    (o_entropy_out)
    );

endmodule

/* rtl/edcu_checker.sv */
// ============================================================================
// edcu_checker - port-level assertions for the congestion window unit
// Watches the top-level ports only; attached by the bind at the end.
// ============================================================================
module edcu_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          push,
    input logic                          full,
    input logic                          empty,
    input logic                          pop,
    input logic [edcu_pkg::WORD_W-1:0]   o_cwnd_out,
    input logic [edcu_pkg::WORD_W-1:0]   o_ai_count_out,
    input logic [edcu_pkg::PLAST_W-1:0]  o_plasticity_out,
    input logic [edcu_pkg::ENT_W-1:0]    o_entropy_out
);
    import edcu_pkg::*;

    // reset drains the result side
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> empty)
        else $error("result queue not empty after reset");

    // plasticity never leaves its saturating range
    a_plast_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> (o_plasticity_out <= PLAST_MAX))
        else $error("plasticity above ceiling");

    // entropy is a transition count of an 8-bit history
    a_ent_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> (o_entropy_out <= ENT_MAX))
        else $error("entropy above history length");

    // the input side fills up only through a push
    a_full_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(full) |-> $past(push))
        else $error("full rose without a push");

    // a waiting result holds until popped
    a_result_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_cwnd_out) && $stable(o_ai_count_out)))
        else $error("waiting result changed or vanished");

endmodule

bind entropy_damped_cwnd_update_unit edcu_checker u_edcu_checker (.*);
